### rtl/sbr_pkg.sv
`default_nettype none

package sbr_pkg;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_ROTATE = 2'd2;

    localparam logic [6:0] SIDE_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CAP,
        ST_ROT_R0,
        ST_ROT_R1,
        ST_ROT_W0,
        ST_ROT_R2,
        ST_ROT_W1,
        ST_ROT_R3,
        ST_ROT_W2,
        ST_ROT_W3,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        POS_IN,
        POS_P0,
        POS_P1,
        POS_P2,
        POS_P3
    } pos_sel_t;

    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_Q,
        WSEL_TEMP
    } wsel_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_FAIL,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic     mem_en;
        logic     mem_we;
        pos_sel_t pos;
        wsel_t    wsel;
        logic     temp_load;
        logic     item_load;
        logic     ring_step;
        logic     res_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_write;
        logic is_read;
        logic is_rotate;
        logic cell_ok;
        logic block_ok;
        logic rad_zero;
        logic ring_last;
        logic block_last;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/sbr_ctrl.sv
`default_nettype none

module sbr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire sbr_pkg::dp_status_t st,
    output sbr_pkg::dp_cmd_t        cmd,
    output logic                    busy,
    output logic                    done
);

    sbr_pkg::state_t state_reg;
    sbr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (st.is_read && st.cell_ok)
                    begin
                        state_next = sbr_pkg::ST_RD_CAP;
                    end
                    else if (st.is_rotate && st.block_ok && !st.rad_zero)
                    begin
                        state_next = sbr_pkg::ST_ROT_R0;
                    end
                    else
                    begin
                        state_next = sbr_pkg::ST_DONE;
                    end
                end
            end
            sbr_pkg::ST_RD_CAP: state_next = sbr_pkg::ST_DONE;
            sbr_pkg::ST_ROT_R0: state_next = sbr_pkg::ST_ROT_R1;
            sbr_pkg::ST_ROT_R1: state_next = sbr_pkg::ST_ROT_W0;
            sbr_pkg::ST_ROT_W0: state_next = sbr_pkg::ST_ROT_R2;
            sbr_pkg::ST_ROT_R2: state_next = sbr_pkg::ST_ROT_W1;
            sbr_pkg::ST_ROT_W1: state_next = sbr_pkg::ST_ROT_R3;
            sbr_pkg::ST_ROT_R3: state_next = sbr_pkg::ST_ROT_W2;
            sbr_pkg::ST_ROT_W2: state_next = sbr_pkg::ST_ROT_W3;
            sbr_pkg::ST_ROT_W3:
            begin
                if (st.ring_last && st.block_last)
                begin
                    state_next = sbr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sbr_pkg::ST_ROT_R0;
                end
            end
            sbr_pkg::ST_DONE: state_next = sbr_pkg::ST_IDLE;
            default: state_next = sbr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '{mem_en: 1'b0, mem_we: 1'b0, pos: sbr_pkg::POS_IN, wsel: sbr_pkg::WSEL_IN,
                temp_load: 1'b0, item_load: 1'b0, ring_step: 1'b0, res_load: 1'b0,
                res_sel: sbr_pkg::RES_FAIL};
        busy = (state_reg != sbr_pkg::ST_IDLE);
        done = (state_reg == sbr_pkg::ST_DONE);
        case (state_reg)
            sbr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.item_load = 1'b1;
                    cmd.res_load  = 1'b1;
                    if ((st.is_write || st.is_read) && st.cell_ok)
                    begin
                        cmd.mem_en  = 1'b1;
                        cmd.mem_we  = st.is_write;
                        cmd.res_sel = sbr_pkg::RES_OK;
                    end
                    else if (st.is_rotate && st.block_ok)
                    begin
                        cmd.res_sel = sbr_pkg::RES_OK;
                    end
                end
            end
            sbr_pkg::ST_RD_CAP:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = sbr_pkg::RES_READ;
            end
            sbr_pkg::ST_ROT_R0:
            begin
                cmd.mem_en = 1'b1;
                cmd.pos    = sbr_pkg::POS_P0;
            end
            sbr_pkg::ST_ROT_R1:
            begin
                cmd.mem_en    = 1'b1;
                cmd.pos       = sbr_pkg::POS_P1;
                cmd.temp_load = 1'b1;
            end
            sbr_pkg::ST_ROT_W0:
            begin
                cmd.mem_en = 1'b1;
                cmd.mem_we = 1'b1;
                cmd.pos    = sbr_pkg::POS_P0;
                cmd.wsel   = sbr_pkg::WSEL_Q;
            end
            sbr_pkg::ST_ROT_R2:
            begin
                cmd.mem_en = 1'b1;
                cmd.pos    = sbr_pkg::POS_P2;
            end
            sbr_pkg::ST_ROT_W1:
            begin
                cmd.mem_en = 1'b1;
                cmd.mem_we = 1'b1;
                cmd.pos    = sbr_pkg::POS_P1;
                cmd.wsel   = sbr_pkg::WSEL_Q;
            end
            sbr_pkg::ST_ROT_R3:
            begin
                cmd.mem_en = 1'b1;
                cmd.pos    = sbr_pkg::POS_P3;
            end
            sbr_pkg::ST_ROT_W2:
            begin
                cmd.mem_en = 1'b1;
                cmd.mem_we = 1'b1;
                cmd.pos    = sbr_pkg::POS_P2;
                cmd.wsel   = sbr_pkg::WSEL_Q;
            end
            sbr_pkg::ST_ROT_W3:
            begin
                cmd.mem_en    = 1'b1;
                cmd.mem_we    = 1'b1;
                cmd.pos       = sbr_pkg::POS_P3;
                cmd.wsel      = sbr_pkg::WSEL_TEMP;
                cmd.ring_step = 1'b1;
            end
            sbr_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sbr_dp.sv
`default_nettype none

module sbr_dp #(
    parameter int MAX_SIDE   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [6:0]          cfg_data,
    input  wire logic [1:0]          kind,
    input  wire logic [5:0]          row,
    input  wire logic [5:0]          col,
    input  wire logic [4:0]          radius,
    input  wire logic                clockwise,
    input  wire logic [31:0]         write_value,
    input  wire sbr_pkg::dp_cmd_t    cmd,
    output sbr_pkg::dp_status_t      st,
    output logic [31:0]              read_value,
    output logic                     status
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] q_reg;
    logic [VALUE_BITS-1:0] temp_reg;

    logic [6:0]  side_reg;
    logic [5:0]  cr_reg;
    logic [5:0]  cc_reg;
    logic [4:0]  rad_reg;
    logic        ccw_reg;
    logic [4:0]  j_reg;
    logic [4:0]  j_next;
    logic [5:0]  t_reg;
    logic [5:0]  t_next;
    logic [31:0] res_value_reg;
    logic        res_status_reg;

    logic [6:0] sum_r;
    logic [6:0] sum_c;
    logic [6:0] lo_r;
    logic [6:0] hi_r;
    logic [6:0] lo_c;
    logic [6:0] hi_c;
    logic [6:0] t7;
    logic [6:0] pa_r;
    logic [6:0] pa_c;
    logic [6:0] pb_r;
    logic [6:0] pb_c;
    logic [6:0] sel_r;
    logic [6:0] sel_c;
    logic [AW-1:0] addr;
    logic [VALUE_BITS-1:0] wdata;

    always_comb
    begin
        sum_r = {1'b0, row} + {2'b00, radius};
        sum_c = {1'b0, col} + {2'b00, radius};
        st.is_write   = (kind == sbr_pkg::KIND_WRITE);
        st.is_read    = (kind == sbr_pkg::KIND_READ);
        st.is_rotate  = (kind == sbr_pkg::KIND_ROTATE);
        st.cell_ok    = ({1'b0, row} < side_reg) && ({1'b0, col} < side_reg)
                        && (int'(row) < MAX_SIDE) && (int'(col) < MAX_SIDE);
        st.block_ok   = (row >= {1'b0, radius}) && (col >= {1'b0, radius})
                        && (sum_r < side_reg) && (sum_c < side_reg)
                        && (int'(sum_r) < MAX_SIDE) && (int'(sum_c) < MAX_SIDE);
        st.rad_zero   = (radius == 5'd0);
        st.ring_last  = (t_reg == ({j_reg, 1'b0} - 6'd1));
        st.block_last = (j_reg == rad_reg);
    end

    always_comb
    begin
        lo_r = {1'b0, cr_reg} - {2'b00, j_reg};
        hi_r = {1'b0, cr_reg} + {2'b00, j_reg};
        lo_c = {1'b0, cc_reg} - {2'b00, j_reg};
        hi_c = {1'b0, cc_reg} + {2'b00, j_reg};
        t7   = {1'b0, t_reg};
        pa_r = hi_r - t7;
        pa_c = lo_c;
        pb_r = lo_r + t7;
        pb_c = hi_c;
        case (cmd.pos)
            sbr_pkg::POS_IN:
            begin
                sel_r = {1'b0, row};
                sel_c = {1'b0, col};
            end
            sbr_pkg::POS_P0:
            begin
                sel_r = lo_r;
                sel_c = lo_c + t7;
            end
            sbr_pkg::POS_P1:
            begin
                sel_r = ccw_reg ? pb_r : pa_r;
                sel_c = ccw_reg ? pb_c : pa_c;
            end
            sbr_pkg::POS_P2:
            begin
                sel_r = hi_r;
                sel_c = hi_c - t7;
            end
            sbr_pkg::POS_P3:
            begin
                sel_r = ccw_reg ? pa_r : pb_r;
                sel_c = ccw_reg ? pa_c : pb_c;
            end
            default:
            begin
                sel_r = {1'b0, row};
                sel_c = {1'b0, col};
            end
        endcase
        addr = AW'(sel_r) * AW'(MAX_SIDE) + AW'(sel_c);
        case (cmd.wsel)
            sbr_pkg::WSEL_IN:   wdata = VALUE_BITS'(write_value[SW-1:0]);
            sbr_pkg::WSEL_Q:    wdata = q_reg;
            sbr_pkg::WSEL_TEMP: wdata = temp_reg;
            default:            wdata = VALUE_BITS'(write_value[SW-1:0]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_en)
        begin
            if (cmd.mem_we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                q_reg <= mem[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.temp_load)
        begin
            temp_reg <= q_reg;
        end
        if (cmd.item_load)
        begin
            cr_reg  <= row;
            cc_reg  <= col;
            rad_reg <= radius;
            ccw_reg <= clockwise;
        end
    end

    always_comb
    begin
        j_next = j_reg;
        t_next = t_reg;
        if (cmd.item_load)
        begin
            j_next = 5'd1;
            t_next = 6'd0;
        end
        else if (cmd.ring_step)
        begin
            if (st.ring_last)
            begin
                j_next = j_reg + 5'd1;
                t_next = 6'd0;
            end
            else
            begin
                t_next = t_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg       <= sbr_pkg::SIDE_RESET;
            j_reg          <= 5'd1;
            t_reg          <= 6'd0;
            res_value_reg  <= 32'd0;
            res_status_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                side_reg <= cfg_data;
            end
            j_reg <= j_next;
            t_reg <= t_next;
            if (cmd.res_load)
            begin
                case (cmd.res_sel)
                    sbr_pkg::RES_OK:
                    begin
                        res_value_reg  <= 32'd0;
                        res_status_reg <= 1'b0;
                    end
                    sbr_pkg::RES_READ:
                    begin
                        res_value_reg  <= 32'(q_reg[SW-1:0]);
                        res_status_reg <= 1'b0;
                    end
                    default:
                    begin
                        res_value_reg  <= 32'd0;
                        res_status_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign read_value = res_value_reg;
    assign status     = res_status_reg;

endmodule

`default_nettype wire

### rtl/square_block_rotator_core.sv
// Square block rotator: a MAX_SIDE by MAX_SIDE tile of cells held in one
// single-port memory, of which the top-left side_in_use square is in use.
// An item is taken when start is high and busy is low. It carries kind
// (write, read or rotate), row, col, radius, clockwise and write_value.
// Each item gives exactly one result: read_value and status are valid for
// the single cycle in which done is high, and the receiver cannot hold
// them off. Status 1 means the kind was unused or the cell or block lay
// outside the tile in use. A write, a failed item and a rotate of radius
// zero show done in the cycle after the item is taken; a read passes
// through a capture state first. A rotate of radius r moves r*(r+1)
// groups of four cells, each taking four reads and four writes in turn
// through the single memory port. Busy drops the cycle after done, when the
// next item may be taken. The side_in_use register is written through
// cfg_write and cfg_data; the user must do this only while the block is
// idle, which the block itself does not enforce. Reset sets it to 64 and
// returns the controller to idle; cell contents are undefined until written.
`default_nettype none

module square_block_rotator_core #(
    parameter int MAX_SIDE   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  row,
    input  wire logic [5:0]  col,
    input  wire logic [4:0]  radius,
    input  wire logic        clockwise,
    input  wire logic [31:0] write_value,
    output logic             done,
    output logic [31:0]      read_value,
    output logic             status
);

    sbr_pkg::dp_cmd_t    cmd;
    sbr_pkg::dp_status_t st;

    sbr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sbr_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .row         (row),
        .col         (col),
        .radius      (radius),
        .clockwise   (clockwise),
        .write_value (write_value),
        .cmd         (cmd),
        .st          (st),
        .read_value  (read_value),
        .status      (status)
    );

endmodule

`default_nettype wire

### rtl/sbr_checker.sv
`default_nettype none

module sbr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] read_value,
    input wire logic        status
);

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done seen while not busy");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done lasted more than one cycle");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy stayed high after done");

    a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (read_value == 32'd0))
        else $error("failed item returned a nonzero value");

endmodule

bind square_block_rotator_core sbr_checker u_sbr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .status     (status)
);

`default_nettype wire

### tb/square_block_rotator_core_test.sv
module square_block_rotator_core_test;

    localparam int TILE_SIDE = 64;
    localparam int ROT_WINDOW = 5;
    localparam int MAX_GAP = 18;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [4:0]  radius;
        logic        clockwise;
        logic [31:0] write_value;
        int unsigned gap;
    } cell_cmd_t;

    typedef struct {
        logic [31:0] read_value;
        logic        status;
    } cell_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [6:0]  cfg_data = 7'd0;
    logic        start = 1'b0;
    logic [1:0]  kind = 2'd0;
    logic [5:0]  row = 6'd0;
    logic [5:0]  col = 6'd0;
    logic [4:0]  radius = 5'd0;
    logic        clockwise = 1'b0;
    logic [31:0] write_value = 32'd0;
    logic        busy;
    logic        done;
    logic [31:0] read_value;
    logic        status;

    square_block_rotator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .row         (row),
        .col         (col),
        .radius      (radius),
        .clockwise   (clockwise),
        .write_value (write_value),
        .done        (done),
        .read_value  (read_value),
        .status      (status)
    );

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    // Predicted tile contents, updated as items are taken, and side register, updated on cfg_write.
    logic [31:0]  tile_model [TILE_SIDE][TILE_SIDE];
    logic [6:0]   side_model = sbr_pkg::SIDE_RESET;
    cell_result_t awaited_results [$];

    int n_writes = 0;
    int n_reads = 0;
    int n_rotates = 0;
    int n_rejected = 0;
    int widest_radius = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Stimulus side: items waiting to be offered, and which cells hold a value.
    cell_cmd_t   pending_cmds [$];
    cell_cmd_t   offer;
    bit          holding = 1'b0;
    bit          item_taken = 1'b0;
    int unsigned hold_off = 0;
    bit          filled [TILE_SIDE][TILE_SIDE];
    int          gen_side = TILE_SIDE;
    int unsigned gap_ceiling = MAX_GAP;

    function automatic cell_result_t apply_to_tile(cell_cmd_t c);
        cell_result_t res;
        logic [31:0]  turned [63][63];
        int           side;
        int           cr;
        int           cc;
        int           rad;
        side = (side_model > TILE_SIDE) ? TILE_SIDE : int'(side_model);
        cr = int'(c.row);
        cc = int'(c.col);
        rad = int'(c.radius);
        res.read_value = '0;
        res.status = STATUS_REJECTED;
        case (c.kind)
            sbr_pkg::KIND_WRITE, sbr_pkg::KIND_READ:
            begin
                if (cr < side && cc < side)
                begin
                    if (c.kind == sbr_pkg::KIND_WRITE)
                    begin
                        tile_model[cr][cc] = c.write_value;
                        n_writes++;
                    end
                    else
                    begin
                        res.read_value = tile_model[cr][cc];
                        n_reads++;
                    end
                    res.status = STATUS_DONE;
                end
            end
            sbr_pkg::KIND_ROTATE:
            begin
                if (cr >= rad && cc >= rad && cr + rad < side && cc + rad < side)
                begin
                    for (int dr = -rad; dr <= rad; dr++)
                    begin
                        for (int dc = -rad; dc <= rad; dc++)
                        begin
                            if (c.clockwise)
                                turned[dr + rad][dc + rad] = tile_model[cr + dc][cc - dr];
                            else
                                turned[dr + rad][dc + rad] = tile_model[cr - dc][cc + dr];
                        end
                    end
                    for (int dr = -rad; dr <= rad; dr++)
                    begin
                        for (int dc = -rad; dc <= rad; dc++)
                            tile_model[cr + dr][cc + dc] = turned[dr + rad][dc + rad];
                    end
                    n_rotates++;
                    if (rad > widest_radius)
                        widest_radius = rad;
                    res.status = STATUS_DONE;
                end
            end
            default:
            begin
            end
        endcase
        if (res.status == STATUS_REJECTED)
            n_rejected++;
        return res;
    endfunction

    always @(posedge clk)
    begin
        cell_result_t want;
        cell_cmd_t    taken;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("square_block_rotator_core_test: no finish within %0d cycles", CYCLE_LIMIT);
            $display("square_block_rotator_core_test: done, errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                results_checked++;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Result read_value %h status %0d arrived with none awaited.",
                                 read_value, status);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (read_value !== want.read_value || status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("Result %0d: expected read_value %h status %0d, got %h %0d.",
                                     results_checked, want.read_value, want.status,
                                     read_value, status);
                    end
                end
            end
            if (cfg_write)
                side_model = cfg_data;
            if (start && !busy)
            begin
                taken.kind = kind;
                taken.row = row;
                taken.col = col;
                taken.radius = radius;
                taken.clockwise = clockwise;
                taken.write_value = write_value;
                taken.gap = 0;
                awaited_results.push_back(apply_to_tile(taken));
                item_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        logic next_start;
        next_start = start;
        if (rst_n)
        begin
            if (item_taken)
            begin
                item_taken = 1'b0;
                holding = 1'b0;
                next_start = 1'b0;
            end
            if (!holding && pending_cmds.size() != 0)
            begin
                offer = pending_cmds.pop_front();
                hold_off = offer.gap;
                holding = 1'b1;
            end
            if (holding && !next_start)
            begin
                if (hold_off == 0)
                begin
                    kind <= offer.kind;
                    row <= offer.row;
                    col <= offer.col;
                    radius <= offer.radius;
                    clockwise <= offer.clockwise;
                    write_value <= offer.write_value;
                    next_start = 1'b1;
                end
                else
                begin
                    hold_off--;
                end
            end
        end
        start <= next_start;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9, 0))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_cmd(input logic [1:0] k, input int r, input int c, input int rad,
                             input bit ccw, input logic [31:0] v);
        cell_cmd_t cmd;
        cmd.kind = k;
        cmd.row = r[5:0];
        cmd.col = c[5:0];
        cmd.radius = rad[4:0];
        cmd.clockwise = ccw;
        cmd.write_value = v;
        cmd.gap = $urandom_range(gap_ceiling, 0);
        if (k == sbr_pkg::KIND_WRITE && r < gen_side && c < gen_side)
            filled[r][c] = 1'b1;
        pending_cmds.push_back(cmd);
    endtask

    // Cells are given a value before anything can read them or turn them into view.
    task automatic ensure_filled(input int r, input int c);
        if (r < gen_side && c < gen_side && !filled[r][c])
            queue_cmd(sbr_pkg::KIND_WRITE, r, c, 0, 1'b0, pick_value());
    endtask

    task automatic queue_read(input int r, input int c);
        ensure_filled(r, c);
        queue_cmd(sbr_pkg::KIND_READ, r, c, $urandom_range(31, 0),
                  1'($urandom_range(1, 0)), pick_value());
    endtask

    task automatic queue_rotate(input int r, input int c, input int rad, input bit ccw);
        if (r >= rad && c >= rad && r + rad < gen_side && c + rad < gen_side)
        begin
            for (int i = r - rad; i <= r + rad; i++)
            begin
                for (int j = c - rad; j <= c + rad; j++)
                    ensure_filled(i, j);
            end
        end
        queue_cmd(sbr_pkg::KIND_ROTATE, r, c, rad, ccw, pick_value());
    endtask

    // Rotates of nonzero radius that fit stay inside a small corner window so that few cells need a first value.
    task automatic random_ops(input int count);
        int r;
        int c;
        int rad;
        int widest;
        int span;
        repeat (count)
        begin
            r = $urandom_range(63, 0);
            c = $urandom_range(63, 0);
            rad = $urandom_range(31, 0);
            case ($urandom_range(19, 0))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    if (gen_side == 0 || $urandom_range(6, 0) == 0)
                    begin
                        if (rad > 0 && r >= rad && c >= rad && r + rad < gen_side
                            && c + rad < gen_side)
                            r = rad - 1;
                        queue_rotate(r, c, rad, 1'($urandom_range(1, 0)));
                    end
                    else
                    begin
                        span = (gen_side < ROT_WINDOW) ? gen_side : ROT_WINDOW;
                        widest = (span - 1) / 2;
                        rad = $urandom_range(widest, 0);
                        r = $urandom_range(span - 1 - rad, rad);
                        c = $urandom_range(span - 1 - rad, rad);
                        queue_rotate(r, c, rad, 1'($urandom_range(1, 0)));
                        repeat ($urandom_range(2, 1))
                            queue_read($urandom_range(r + rad, r - rad),
                                       $urandom_range(c + rad, c - rad));
                    end
                end
                8, 9, 10, 11, 12:
                    queue_cmd(sbr_pkg::KIND_WRITE, r, c, rad, 1'($urandom_range(1, 0)),
                              pick_value());
                13, 14, 15, 16, 17, 18:
                    queue_read(r, c);
                default:
                    queue_cmd(KIND_UNUSED, r, c, rad, 1'($urandom_range(1, 0)), pick_value());
            endcase
        end
    endtask

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || holding || start || awaited_results.size() != 0
               || busy);
    endtask

    task automatic set_side(input logic [6:0] v);
        wait_until_idle();
        cfg_data <= v;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        gen_side = (v > TILE_SIDE) ? TILE_SIDE : int'(v);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_cmd(sbr_pkg::KIND_WRITE, 0, 0, 0, 1'b0, 32'h0000_0000);
        queue_cmd(sbr_pkg::KIND_WRITE, 63, 63, 31, 1'b1, 32'hFFFF_FFFF);
        queue_cmd(sbr_pkg::KIND_WRITE, 0, 63, 0, 1'b0, $urandom());
        queue_cmd(sbr_pkg::KIND_WRITE, 63, 0, 0, 1'b1, $urandom());
        queue_read(0, 0);
        queue_read(63, 63);
        queue_read(0, 63);
        queue_read(63, 0);
        queue_cmd(KIND_UNUSED, 63, 63, 31, 1'b1, 32'hFFFF_FFFF);
        queue_rotate(0, 0, 1, 1'b0);
        queue_rotate(40, 31, 31, 1'b1);
        queue_rotate(63, 63, 0, 1'b0);
        queue_rotate(62, 62, 1, 1'b0);
        queue_rotate(1, 1, 1, 1'b1);
        queue_read(63, 63);
        queue_read(0, 2);

        gap_ceiling = 0;
        random_ops(5);
        gap_ceiling = MAX_GAP;

        set_side(7'd0);
        queue_cmd(sbr_pkg::KIND_WRITE, 0, 0, 0, 1'b0, pick_value());
        queue_read(0, 0);
        queue_rotate(0, 0, 0, 1'b1);
        random_ops(2);

        set_side(7'd1);
        queue_read(0, 0);
        queue_read(1, 0);
        queue_cmd(sbr_pkg::KIND_WRITE, 0, 1, 0, 1'b0, pick_value());
        queue_rotate(0, 0, 0, 1'b0);
        queue_rotate(0, 0, 1, 1'b1);
        random_ops(2);

        set_side(7'd127);
        queue_rotate(62, 62, 1, 1'b1);
        queue_rotate(33, 33, 31, 1'b0);
        queue_read(32, 32);
        queue_read(1, 63);
        queue_read(63, 1);
        random_ops(5);

        set_side(7'd37);
        random_ops(5);

        set_side(sbr_pkg::SIDE_RESET);
        gap_ceiling = 0;
        random_ops(4);
        gap_ceiling = MAX_GAP;
        random_ops(5);

        wait_until_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Run covered %0d writes, %0d reads, %0d rotates up to radius %0d, %0d rejected.",
                 n_writes, n_reads, n_rotates, widest_radius, n_rejected);
        $display("Tile sides 64, 0, 1, 127 and 37 were used; %0d results checked, %0d mismatched.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("square_block_rotator_core_test: done, clean");
        else
            $display("square_block_rotator_core_test: done, errors");
        $finish;
    end

endmodule
